>>> rtl/command_frame_deframer_decoder_top_assert.svh
// Assertion macros used by the checker file of the frame decoder.
`ifndef COMMAND_FRAME_DEFRAMER_DECODER_TOP_ASSERT_SVH
`define COMMAND_FRAME_DEFRAMER_DECODER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CFDD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame decoder assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CFDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame decoder assertion failed");

`endif

>>> rtl/cfdd_pkg.sv
// Shared widths, codes and types of the command frame decoder.
`default_nettype none
package cfdd_pkg;

    localparam int BYTE_W     = 8;
    localparam int SEL_W      = 4;
    localparam int VALUE_W    = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEADER  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TRAILER = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DISABLE = 8'd3;

    localparam logic [BYTE_W-1:0] RST_HEADER  = 8'h00;
    localparam logic [BYTE_W-1:0] RST_TRAILER = 8'hFF;
    localparam logic [BYTE_W-1:0] RST_ENABLE  = 8'h01;
    localparam logic [BYTE_W-1:0] RST_DISABLE = 8'h00;

    // command codes
    localparam logic [BYTE_W-1:0] CMD_MOTOR  = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_PID    = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_TARGET = 8'h03;

    // PID loop and gain nibbles
    localparam logic [3:0] NIBBLE_MASK = 4'hF;
    localparam logic [3:0] LOOP_Q   = 4'h1;
    localparam logic [3:0] LOOP_D   = 4'h2;
    localparam logic [3:0] LOOP_SPD = 4'h3;
    localparam logic [3:0] LOOP_POS = 4'h4;
    localparam logic [3:0] GAIN_KP  = 4'h1;
    localparam logic [3:0] GAIN_KI  = 4'h2;
    localparam logic [3:0] GAIN_KD  = 4'h3;

    // target subcommands
    localparam logic [BYTE_W-1:0] TGT_IQ  = 8'h01;
    localparam logic [BYTE_W-1:0] TGT_POS = 8'h03;

    // target selector bases
    localparam logic [SEL_W-1:0] SEL_MOTOR    = 4'd0;
    localparam logic [SEL_W-1:0] SEL_Q_BASE   = 4'd0;
    localparam logic [SEL_W-1:0] SEL_D_BASE   = 4'd2;
    localparam logic [SEL_W-1:0] SEL_SPD_BASE = 4'd4;
    localparam logic [SEL_W-1:0] SEL_POS_BASE = 4'd7;
    localparam logic [SEL_W-1:0] SEL_TGT_BASE = 4'd10;
    localparam logic [SEL_W-1:0] SEL_MAX      = 4'd13;

    typedef struct packed {
        logic [BYTE_W-1:0]  cmd;
        logic [BYTE_W-1:0]  sub;
        logic [VALUE_W-1:0] payload;
    } t_frame;

    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] trailer;
        logic [BYTE_W-1:0] enable;
        logic [BYTE_W-1:0] disable_code;
    } t_cfg;

endpackage
`default_nettype wire

>>> rtl/cfdd_byte_if.sv
// Byte stream channel: valid, ready and one received byte.
`default_nettype none
interface cfdd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [cfdd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/cfdd_res_if.sv
// Result channel: valid, ready and one parameter write.
`default_nettype none
interface cfdd_res_if;
    logic                        valid;
    logic                        ready;
    logic [cfdd_pkg::SEL_W-1:0]   target_sel;
    logic [cfdd_pkg::VALUE_W-1:0] write_value;

    modport source (output valid, output target_sel, output write_value, input ready);
    modport sink   (input valid, input target_sel, input write_value, output ready);
endinterface
`default_nettype wire

>>> rtl/cfdd_cfg_if.sv
// Configuration write channel: valid, ready, register index and data.
`default_nettype none
interface cfdd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cfdd_pkg::CFG_IDX_W-1:0]  index;
    logic [cfdd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/cfdd_parser.sv
// Front end: hunts for the header, collects a frame and checks the trailer.
`default_nettype none
module cfdd_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    cfdd_byte_if.sink            i_rx,
    input  cfdd_pkg::t_cfg       i_cfg,
    input  cfdd_pkg::t_qstat     i_qstat,
    output cfdd_pkg::t_push      o_push
);

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_DATA,
        ST_TAIL
    } t_state;

    localparam logic [2:0] IDX_ZERO = 3'd0;
    localparam logic [2:0] IDX_CMD  = 3'd1;
    localparam logic [2:0] IDX_SUB  = 3'd2;
    localparam logic [2:0] IDX_PAY0 = 3'd3;
    localparam logic [2:0] IDX_PAYN = 3'd6;
    localparam logic [2:0] IDX_TAIL = 3'd7;

    t_state                         r_state, n_state;
    logic [2:0]                     r_idx, n_idx;
    logic [cfdd_pkg::BYTE_W-1:0]    r_cmd, n_cmd;
    logic [cfdd_pkg::BYTE_W-1:0]    r_sub, n_sub;
    logic [cfdd_pkg::VALUE_W-1:0]   r_payload, n_payload;

    logic       accept;
    logic [2:0] lane_idx;
    logic [4:0] lane_ofs;

    // one frame slot must be free before any word is taken
    assign i_rx.ready = !i_qstat.full;
    assign accept     = i_rx.valid && i_rx.ready;
    assign lane_idx   = r_idx - IDX_PAY0;
    assign lane_ofs   = {lane_idx[1:0], 3'b000};

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cmd     = r_cmd;
        n_sub     = r_sub;
        n_payload = r_payload;
        o_push.valid       = 1'b0;
        o_push.frame.cmd     = r_cmd;
        o_push.frame.sub     = r_sub;
        o_push.frame.payload = r_payload;
        if (accept) begin
            unique case (r_state)
                ST_HUNT: begin
                    if (i_rx.rx_byte == i_cfg.header) begin
                        n_idx   = IDX_CMD;
                        n_state = ST_DATA;
                    end
                end
                ST_DATA: begin
                    if (r_idx == IDX_CMD) begin
                        n_cmd = i_rx.rx_byte;
                    end else if (r_idx == IDX_SUB) begin
                        n_sub = i_rx.rx_byte;
                    end else if (r_idx >= IDX_PAY0 && r_idx <= IDX_PAYN) begin
                        n_payload[lane_ofs +: cfdd_pkg::BYTE_W] = i_rx.rx_byte;
                    end
                    n_idx = r_idx + 3'd1;
                    if (n_idx == IDX_TAIL || n_idx == IDX_ZERO) begin
                        n_state = ST_TAIL;
                    end
                end
                ST_TAIL: begin
                    // a bad trailer drops the frame, either way hunt again
                    o_push.valid = (i_rx.rx_byte == i_cfg.trailer);
                    n_state = ST_HUNT;
                    n_idx   = IDX_ZERO;
                end
                default: begin
                    n_state = ST_HUNT;
                    n_idx   = IDX_ZERO;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_idx   <= IDX_ZERO;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
        r_cmd     <= n_cmd;
        r_sub     <= n_sub;
        r_payload <= n_payload;
    end

endmodule
`default_nettype wire

>>> rtl/cfdd_queue.sv
// Short frame queue between the parser and the decoder.
`default_nettype none
module cfdd_queue #(
    parameter int P_DEPTH = cfdd_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  cfdd_pkg::t_push     i_push,
    input  wire logic           i_pop,
    output cfdd_pkg::t_qstat    o_qstat,
    output cfdd_pkg::t_frame    o_head
);

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(P_DEPTH);

    cfdd_pkg::t_frame r_mem [P_DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    logic do_push, do_pop;

    assign o_qstat.full  = (r_count == FULL_CNT);
    assign o_qstat.empty = (r_count == '0);
    assign do_push = i_push.valid && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.frame;
        end
    end

endmodule
`default_nettype wire

>>> rtl/cfdd_decoder.sv
// Back end: decodes queued frames into parameter writes with an output register.
`default_nettype none
module cfdd_decoder (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  cfdd_pkg::t_qstat    i_qstat,
    input  cfdd_pkg::t_frame    i_head,
    input  cfdd_pkg::t_cfg      i_cfg,
    output logic                o_pop,
    cfdd_res_if.source          o_res
);

    logic                          r_valid;
    logic [cfdd_pkg::SEL_W-1:0]    r_sel;
    logic [cfdd_pkg::VALUE_W-1:0]  r_value;

    logic                          hit;
    logic [cfdd_pkg::SEL_W-1:0]    sel;
    logic [cfdd_pkg::VALUE_W-1:0]  value;
    logic [3:0]                    loop_nib, gain_nib;
    logic                          gain_ok;

    assign loop_nib = i_head.sub[7:4] & cfdd_pkg::NIBBLE_MASK;
    assign gain_nib = i_head.sub[3:0] & cfdd_pkg::NIBBLE_MASK;
    assign gain_ok  = (gain_nib == cfdd_pkg::GAIN_KP) || (gain_nib == cfdd_pkg::GAIN_KI)
                   || (gain_nib == cfdd_pkg::GAIN_KD);

    always_comb begin
        hit   = 1'b0;
        sel   = cfdd_pkg::SEL_MOTOR;
        value = i_head.payload;
        unique case (i_head.cmd)
            cfdd_pkg::CMD_MOTOR: begin
                // enable wins when both codes are equal
                if (i_head.sub == i_cfg.enable) begin
                    hit   = 1'b1;
                    value = cfdd_pkg::VALUE_W'(1);
                end else if (i_head.sub == i_cfg.disable_code) begin
                    hit   = 1'b1;
                    value = '0;
                end
            end
            cfdd_pkg::CMD_PID: begin
                if (gain_ok) begin
                    unique case (loop_nib)
                        cfdd_pkg::LOOP_Q: begin
                            hit = (gain_nib != cfdd_pkg::GAIN_KD);
                            sel = cfdd_pkg::SEL_Q_BASE + gain_nib;
                        end
                        cfdd_pkg::LOOP_D: begin
                            hit = (gain_nib != cfdd_pkg::GAIN_KD);
                            sel = cfdd_pkg::SEL_D_BASE + gain_nib;
                        end
                        cfdd_pkg::LOOP_SPD: begin
                            hit = 1'b1;
                            sel = cfdd_pkg::SEL_SPD_BASE + gain_nib;
                        end
                        cfdd_pkg::LOOP_POS: begin
                            hit = 1'b1;
                            sel = cfdd_pkg::SEL_POS_BASE + gain_nib;
                        end
                        default: hit = 1'b0;
                    endcase
                end
            end
            cfdd_pkg::CMD_TARGET: begin
                if (i_head.sub >= cfdd_pkg::TGT_IQ && i_head.sub <= cfdd_pkg::TGT_POS) begin
                    hit = 1'b1;
                    sel = cfdd_pkg::SEL_TGT_BASE + i_head.sub[3:0];
                end
            end
            default: hit = 1'b0;
        endcase
    end

    // take the next frame whenever the output register is free or being drained
    assign o_pop = !i_qstat.empty && (!r_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_res.ready) begin
            r_valid <= o_pop && hit;
        end
        if (o_pop) begin
            r_sel   <= sel;
            r_value <= value;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.target_sel  = r_sel;
    assign o_res.write_value = r_value;

endmodule
`default_nettype wire

>>> rtl/command_frame_deframer_decoder_top.sv
// Top level of the command frame decoder: configuration registers and the two halves.
//
// Usage:
//   i_rx carries one received byte per word. o_res carries one parameter write
//   per word: target_sel picks the parameter, write_value holds the raw 32-bit
//   float bits (1 or 0 for the motor state). i_cfg writes the header, trailer,
//   enable and disable codes at indexes 0 to 3; other indexes are ignored and
//   the channel is always ready. Write it only while no frame is in flight.
//   Throughput is one byte per cycle while the queue is not full. A frame is
//   eight bytes; the write for a good frame passes through the queue and
//   then the decoder's output register before it shows on o_res. Bad
//   trailers and unknown codes give no word.
//   When o_res stalls, the result holds, up to P_QUEUE_DEPTH checked frames
//   wait in the queue, and i_rx.ready drops only once the queue is full.
//   Reset empties the queue and the output, puts the parser back to hunting
//   for a header and loads the register defaults (header 0x00, trailer 0xFF,
//   enable 0x01, disable 0x00).
`default_nettype none
module command_frame_deframer_decoder_top #(
    parameter int P_QUEUE_DEPTH = cfdd_pkg::QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cfdd_byte_if.sink   i_rx,
    cfdd_cfg_if.sink    i_cfg,
    cfdd_res_if.source  o_res
);

    cfdd_pkg::t_cfg   r_cfg;
    cfdd_pkg::t_push  push;
    cfdd_pkg::t_qstat qstat;
    cfdd_pkg::t_frame head;
    logic             pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header       <= cfdd_pkg::RST_HEADER;
            r_cfg.trailer      <= cfdd_pkg::RST_TRAILER;
            r_cfg.enable       <= cfdd_pkg::RST_ENABLE;
            r_cfg.disable_code <= cfdd_pkg::RST_DISABLE;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                cfdd_pkg::CFG_IDX_HEADER:  r_cfg.header       <= i_cfg.data;
                cfdd_pkg::CFG_IDX_TRAILER: r_cfg.trailer      <= i_cfg.data;
                cfdd_pkg::CFG_IDX_ENABLE:  r_cfg.enable       <= i_cfg.data;
                cfdd_pkg::CFG_IDX_DISABLE: r_cfg.disable_code <= i_cfg.data;
                default: ;
            endcase
        end
    end

    cfdd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_cfg   (r_cfg),
        .i_qstat (qstat),
        .o_push  (push)
    );

    cfdd_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_qstat (qstat),
        .o_head  (head)
    );

    cfdd_decoder u_decoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_head  (head),
        .i_cfg   (r_cfg),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire

>>> rtl/cfdd_checker.sv
// Port-level checker of the command frame decoder and its bind to the top level.
`default_nettype none
`include "command_frame_deframer_decoder_top_assert.svh"
module cfdd_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_res_valid,
    input wire logic                         i_res_ready,
    input wire logic [cfdd_pkg::SEL_W-1:0]   i_res_sel,
    input wire logic [cfdd_pkg::VALUE_W-1:0] i_res_value
);

    // a stalled result holds its word
    `CFDD_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready,
        i_res_valid && $stable(i_res_sel) && $stable(i_res_value))

    `CFDD_ASSERT_NOW(a_sel_range, i_clk, i_rst_n, i_res_valid, i_res_sel <= cfdd_pkg::SEL_MAX)

    // motor state writes carry only on or off
    `CFDD_ASSERT_NOW(a_motor_bool, i_clk, i_rst_n,
        i_res_valid && (i_res_sel == cfdd_pkg::SEL_MOTOR),
        i_res_value[cfdd_pkg::VALUE_W-1:1] == '0)

endmodule

bind command_frame_deframer_decoder_top cfdd_checker u_cfdd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_sel   (o_res.target_sel),
    .i_res_value (o_res.write_value)
);
`default_nettype wire
